>>> rtl/lcom_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LiDAR curvature and occlusion marker: shared types and constants
// Field widths, the per-cell point record, the control groups passed between
// the chain, the window evaluator and the output buffer, and register codes.
// ----------------------------------------------------------------------------
package lcom_pkg;

	// Field widths of the point and result transfers.
	localparam int RANGE_W = 18;
	localparam int COL_W   = 12;
	localparam int POS_W   = 16;
	localparam int CURV_W  = 43;
	localparam int RATIO_W = 10;

	// Internal widths: curvature magnitude, ten-point range sum, grazing products.
	localparam int MAG_W  = 22;
	localparam int SUM_W  = 22;
	localparam int PROD_W = 28;

	// Frame positions wrap at this count.
	localparam int FRAME_POINTS_MAX = 65536;

	// Grazing test works in thousandths of the range.
	localparam int GRAZE_SCALE = 1000;
	// Ten neighbors minus ten times the center equals the eleven-point sum
	// minus eleven times the center.
	localparam int CURV_SELF_WEIGHT = 11;
	// Number of older points that must belong to the open frame for a curvature.
	localparam int CURV_SPAN = 10;

	// Chain geometry: cell j holds the point j places behind the newest one.
	localparam int NCELLS     = 11;
	localparam int STEPK_CELL = 1;
	localparam int X11_CELL   = 4;
	localparam int CURV_CELL  = 5;
	localparam int NEAR_LAST  = 5;
	localparam int GRAZE_CELL = 6;

	// Configuration port.
	localparam int APB_DW = 32;
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_OCCL_GAP    = 2'd0;
	localparam logic [1:0] REG_COL_LIMIT   = 2'd1;
	localparam logic [1:0] REG_GRAZE_RATIO = 2'd2;
	localparam logic [RANGE_W-1:0] OCCL_GAP_RST    = RANGE_W'(300);
	localparam logic [COL_W-1:0]   COL_LIMIT_RST   = COL_W'(10);
	localparam logic [RATIO_W-1:0] GRAZE_RATIO_RST = RATIO_W'(20);

	typedef struct packed {
		logic [RANGE_W-1:0] range_mm;
		logic [COL_W-1:0]   column;
		logic               frame_last;
	} point_t;

	typedef struct packed {
		logic [POS_W-1:0]  point_position;
		logic [CURV_W-1:0] curvature;
		logic              curvature_valid;
		logic              picked;
		logic              result_last;
	} result_t;

	typedef struct packed {
		logic [RANGE_W-1:0] occlusion_gap_mm;
		logic [COL_W-1:0]   column_gap_limit;
		logic [RATIO_W-1:0] grazing_ratio_permille;
	} cfg_t;

	// One point as it travels down the chain. Some fields are filled in on the
	// way: step_k when entering the grazing-step cell, range_x11 at the cell
	// feeding the curvature, lim and the curvature at the center cell.
	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic [RANGE_W-1:0] range_mm;
		logic [COL_W-1:0]   column;
		logic               last;
		logic               picked;
		logic               cok;
		logic [MAG_W-1:0]   cmag;
		logic [RANGE_W-1:0] step_mag;
		logic               step_up;
		logic [COL_W-1:0]   col_step;
		logic [PROD_W-1:0]  step_k;
		logic [PROD_W-1:0]  lim;
		logic [SUM_W-1:0]   range_x11;
	} cell_rec_t;

	typedef struct packed {
		logic valid;
		logic done;
	} cell_stat_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic mark;
		logic finish;
	} cell_ctl_t;

	typedef struct packed {
		logic             cok;
		logic [MAG_W-1:0] cmag;
		logic             near;
		logic             far;
		logic             graze;
	} eval_t;

endpackage

>>> rtl/lcom_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LiDAR marker chain cell
// Holds one point record. It loads its upstream neighbor, holds, or empties,
// and can set the picked flag and close the frame as the record comes in.
// ----------------------------------------------------------------------------
module lcom_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcom_pkg::cell_ctl_t  ctl,
	input  lcom_pkg::cell_rec_t  up_rec,
	input  lcom_pkg::cell_stat_t up_stat,
	output lcom_pkg::cell_rec_t  rec,
	output lcom_pkg::cell_stat_t stat
);
	import lcom_pkg::*;

	cell_rec_t rec_q;
	cell_rec_t rec_d;
	logic      valid_q;
	logic      done_q;

	// Incoming record with the occlusion or grazing mark folded in.
	always_comb begin
		rec_d = up_rec;
		rec_d.picked = up_rec.picked | ctl.mark;
	end

	// Occupancy: a loaded point closes with its frame when the end mark passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= up_stat.valid;
			done_q  <= up_stat.valid & (up_stat.done | ctl.finish);
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
			done_q  <= 1'b0;
		end
	end

	// Point record.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rec_q <= rec_d;
		end
	end

	assign rec  = rec_q;
	assign stat = '{valid: valid_q, done: done_q};

endmodule

>>> rtl/lcom_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LiDAR marker window evaluator
// Curvature magnitude for the point entering the center cell, and the
// occlusion and grazing decisions for the point one place older.
// ----------------------------------------------------------------------------
module lcom_eval (
	input  logic [lcom_pkg::RANGE_W-1:0] new_range,
	input  logic [lcom_pkg::SUM_W-1:0]   win_sum,
	input  lcom_pkg::cell_rec_t          near_rec,
	input  lcom_pkg::cell_rec_t          mid_rec,
	input  lcom_pkg::cfg_t               cfg,
	input  logic                         chk_en,
	input  logic                         curv_en,
	output lcom_pkg::eval_t              ev
);
	import lcom_pkg::*;

	logic [SUM_W+1:0] diff;
	logic [SUM_W+1:0] diff_abs;
	logic             col_ok;
	logic             step_big;

	// Eleven-point sum minus eleven times the center, then its magnitude.
	always_comb begin
		diff = (SUM_W+2)'(new_range) + (SUM_W+2)'(win_sum) - (SUM_W+2)'(near_rec.range_x11);
		diff_abs = diff[SUM_W+1] ? (~diff + (SUM_W+2)'(1)) : diff;
	end

	// The step between the center point and its newer neighbor is stored with
	// the newer neighbor; the older step and the threshold with the center.
	assign col_ok   = near_rec.col_step < cfg.column_gap_limit;
	assign step_big = near_rec.step_mag > cfg.occlusion_gap_mm;

	always_comb begin
		ev.cok   = curv_en;
		ev.cmag  = diff_abs[MAG_W-1:0];
		ev.far   = chk_en & col_ok & step_big & ~near_rec.step_up;
		ev.near  = chk_en & col_ok & step_big & near_rec.step_up;
		ev.graze = chk_en & (mid_rec.step_k > mid_rec.lim) & (near_rec.step_k > mid_rec.lim);
	end

endmodule

>>> rtl/lcom_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LiDAR marker configuration registers
// APB-style port holding the occlusion gap, column limit and grazing ratio.
// ----------------------------------------------------------------------------
module lcom_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lcom_pkg::ADDR_W-1:0] paddr,
	input  logic [lcom_pkg::APB_DW-1:0] pwdata,
	output logic [lcom_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output lcom_pkg::cfg_t              cfg
);
	import lcom_pkg::*;

	logic [RANGE_W-1:0] occl_gap_q;
	logic [COL_W-1:0]   col_limit_q;
	logic [RATIO_W-1:0] graze_ratio_q;
	logic               wr_en;
	logic [1:0]         reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occl_gap_q    <= OCCL_GAP_RST;
			col_limit_q   <= COL_LIMIT_RST;
			graze_ratio_q <= GRAZE_RATIO_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_OCCL_GAP:    occl_gap_q    <= pwdata[RANGE_W-1:0];
				REG_COL_LIMIT:   col_limit_q   <= pwdata[COL_W-1:0];
				REG_GRAZE_RATIO: graze_ratio_q <= pwdata[RATIO_W-1:0];
				default:         ;
			endcase
		end
	end

	// Read data.
	always_comb begin
		case (reg_idx)
			REG_OCCL_GAP:    prdata = APB_DW'(occl_gap_q);
			REG_COL_LIMIT:   prdata = APB_DW'(col_limit_q);
			REG_GRAZE_RATIO: prdata = APB_DW'(graze_ratio_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg = '{occlusion_gap_mm: occl_gap_q, column_gap_limit: col_limit_q,
		grazing_ratio_permille: graze_ratio_q};

endmodule

>>> rtl/lcom_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LiDAR marker output buffer
// Two-entry buffer between the chain and the result channel, so that the
// input stall comes from a register and not from the result stall.
// ----------------------------------------------------------------------------
module lcom_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lcom_pkg::result_t push_data,
	output logic              full,
	output logic              out_valid,
	output lcom_pkg::result_t out_data,
	input  logic              out_stall
);
	import lcom_pkg::*;

	result_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = cnt_q != 2'd0;
	assign full      = cnt_q == 2'd2;
	assign pop       = out_valid & ~out_stall;
	assign out_data  = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q ^ push;
			rd_ptr_q <= rd_ptr_q ^ pop;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/lidar_curvature_occlusion_marker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LiDAR curvature and occlusion marker
// Streams one frame of points through a chain of cells, computes curvature,
// marks occluded and grazing points, and emits each point with its marks.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle, every cycle, as long as the
// two-entry result buffer is not full; that buffer is what stalls the input.
// Points sit in a chain of eleven cells and a point is delivered when the
// eleventh newer point of its frame enters, which pushes it into the result
// buffer. The end-of-frame mark closes the frame: the held points (up to
// eleven) then advance one cell per cycle and leave at one per cycle while
// the result buffer is not full, and points of the next frame can already
// be accepted behind them. The user must write configuration through the APB
// port only while no frame is in flight; the block does not enforce this.
module lidar_curvature_occlusion_marker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lcom_pkg::ADDR_W-1:0] paddr,
	input  logic [lcom_pkg::APB_DW-1:0] pwdata,
	output logic [lcom_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	input  logic                        point_valid,
	output logic                        point_stall,
	input  lcom_pkg::point_t            point,
	output logic                        result_valid,
	input  logic                        result_stall,
	output lcom_pkg::result_t           result
);
	import lcom_pkg::*;

	cfg_t              cfg;
	cell_rec_t         rec     [NCELLS];
	cell_stat_t        stat    [NCELLS];
	cell_rec_t         up_rec  [NCELLS];
	cell_stat_t        up_stat [NCELLS];
	cell_ctl_t         ctl     [NCELLS];
	logic [NCELLS-1:0] move_in;
	logic [NCELLS-1:0] live_vec;
	logic [NCELLS-1:0] done_vec;
	cell_rec_t         in_rec;
	eval_t             ev;
	logic              acc;
	logic              drain;
	logic              chk_en;
	logic              curv_en;
	logic              out_full;
	logic              push;
	result_t           push_data;
	logic [2*MAG_W-1:0] curv_sq;
	logic [POS_W-1:0]  pos_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W:0]    sum_next;

	// Configuration registers.
	lcom_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// A full shift per accepted point; otherwise closed frames drain unless full.
	assign point_stall = out_full;
	assign acc         = point_valid & ~point_stall;
	assign drain       = ~acc & ~out_full & (|done_vec);
	assign chk_en      = acc & (&live_vec);
	assign curv_en     = acc & (&live_vec[CURV_SPAN-1:0]);

	// New point record, with its steps to the previous point of the frame.
	always_comb begin
		in_rec           = '0;
		in_rec.pos       = pos_q;
		in_rec.range_mm  = point.range_mm;
		in_rec.column    = point.column;
		in_rec.last      = point.frame_last;
		in_rec.step_up   = point.range_mm > rec[0].range_mm;
		in_rec.step_mag  = in_rec.step_up ? (point.range_mm - rec[0].range_mm)
			: (rec[0].range_mm - point.range_mm);
		in_rec.col_step  = (point.column > rec[0].column) ? (point.column - rec[0].column)
			: (rec[0].column - point.column);
	end

	// Curvature and occlusion decisions over the current window.
	lcom_eval u_eval (
		.new_range (point.range_mm),
		.win_sum   (sum_q),
		.near_rec  (rec[X11_CELL]),
		.mid_rec   (rec[CURV_CELL]),
		.cfg       (cfg),
		.chk_en    (chk_en),
		.curv_en   (curv_en),
		.ev        (ev)
	);

	// The chain of cells.
	for (genvar j = 0; j < NCELLS; j++) begin : g_cell
		if (j == 0) begin : g_head
			always_comb begin
				up_rec[j]  = in_rec;
				up_stat[j] = '{valid: 1'b1, done: 1'b0};
				move_in[j] = 1'b0;
			end
		end else begin : g_body
			// Upstream record, with the fields that this cell position fills in.
			always_comb begin
				up_rec[j]  = rec[j-1];
				up_stat[j] = stat[j-1];
				move_in[j] = stat[j-1].valid & stat[j-1].done;
				if (j == STEPK_CELL) begin
					up_rec[j].step_k = PROD_W'(rec[j-1].step_mag) * PROD_W'(GRAZE_SCALE);
				end
				if (j == X11_CELL) begin
					up_rec[j].range_x11 = SUM_W'(rec[j-1].range_mm) * SUM_W'(CURV_SELF_WEIGHT);
				end
				if (j == CURV_CELL) begin
					up_rec[j].lim = PROD_W'(rec[j-1].range_mm)
						* PROD_W'(cfg.grazing_ratio_permille);
					if (ev.cok) begin
						up_rec[j].cmag = ev.cmag;
						up_rec[j].cok  = 1'b1;
					end
				end
			end
		end

		// Cell control: a closed point moves on during a drain, and leaves its
		// cell empty when nothing closed follows it.
		always_comb begin
			ctl[j].load   = acc | (drain & move_in[j]);
			ctl[j].clear  = drain & ~move_in[j] & stat[j].valid & stat[j].done;
			ctl[j].finish = acc & point.frame_last;
			if (j <= NEAR_LAST) begin
				ctl[j].mark = ev.near;
			end else if (j == GRAZE_CELL) begin
				ctl[j].mark = ev.far | ev.graze;
			end else begin
				ctl[j].mark = ev.far;
			end
		end

		assign live_vec[j] = stat[j].valid & ~stat[j].done;
		assign done_vec[j] = stat[j].valid & stat[j].done;

		lcom_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[j]),
			.up_rec  (up_rec[j]),
			.up_stat (up_stat[j]),
			.rec     (rec[j]),
			.stat    (stat[j])
		);
	end

	// Running range sum over the open frame's points in cells 0 to 9.
	assign sum_next = (SUM_W+1)'(sum_q) + (SUM_W+1)'(point.range_mm)
		- (live_vec[CURV_SPAN-1] ? (SUM_W+1)'(rec[CURV_SPAN-1].range_mm) : '0);

	// Frame position counter and window sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (acc) begin
			if (point.frame_last) begin
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= (pos_q == POS_W'(FRAME_POINTS_MAX - 1)) ? '0 : pos_q + POS_W'(1);
				sum_q <= sum_next[SUM_W-1:0];
			end
		end
	end

	// The point leaving the last cell becomes a result.
	assign push = (acc & stat[NCELLS-1].valid) | (drain & done_vec[NCELLS-1]);
	assign curv_sq = (2*MAG_W)'(rec[NCELLS-1].cmag) * (2*MAG_W)'(rec[NCELLS-1].cmag);

	always_comb begin
		push_data.point_position  = rec[NCELLS-1].pos;
		push_data.curvature       = rec[NCELLS-1].cok ? curv_sq[CURV_W-1:0] : '0;
		push_data.curvature_valid = rec[NCELLS-1].cok;
		push_data.picked          = rec[NCELLS-1].picked | ev.far;
		push_data.result_last     = rec[NCELLS-1].last;
	end

	lcom_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (out_full),
		.out_valid (result_valid),
		.out_data  (result),
		.out_stall (result_stall)
	);

`ifndef NO_ASSERTIONS
	// Points of the open frame always occupy one run of cells starting at cell 0.
	a_live_run: assert property (@(posedge clk) disable iff (!arst_n)
		(live_vec & (live_vec + NCELLS'(1))) == '0)
		else $error("open-frame points are not contiguous in the chain");

	// A result is never pushed into a full output buffer.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !out_full)
		else $error("result pushed into a full output buffer");

	// The end-of-frame mark closes every point of the frame.
	a_frame_close: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && point.frame_last) |=> (live_vec == '0))
		else $error("points of a closed frame still counted as open");
`endif

endmodule

>>> tb/mark_track_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Curvature and occlusion marks: expected-result tracker
// Keeps its own copy of the point windows and the three thresholds, works out
// the marked points that each accepted point transfer releases, and compares
// every result transfer with the oldest one still owed.
// ----------------------------------------------------------------------------
package mark_track_pkg;
	import lcom_pkg::*;

	// Window geometry: index 0 holds the newest point of the frame.
	localparam int WIN_DEPTH = 12;
	localparam int CENTER    = 5;
	localparam int CHECKED   = 6;
	localparam int OLDEST    = 11;
	localparam int NEIGHBORS = 10;

	// Register index that is not in the list; writes to it are ignored.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// Mismatch lines beyond this count are counted but not printed.
	localparam int PRINT_CAP = 30;

	class point_mark_tracker;
		logic [RANGE_W-1:0] occl_gap;
		logic [COL_W-1:0]   col_limit;
		logic [RATIO_W-1:0] graze_ratio;

		logic [RANGE_W-1:0] range_win [WIN_DEPTH];
		logic [COL_W-1:0]   col_win [WIN_DEPTH];
		logic               pick_win [WIN_DEPTH];
		logic [CURV_W-1:0]  curv_win [WIN_DEPTH];
		logic               cok_win [WIN_DEPTH];
		logic [POS_W-1:0]   next_pos;
		int                 held;

		result_t owed_marks [$];

		int errors;
		int points_in;
		int frames;
		int results_seen;
		int picked_seen;
		int curv_seen;

		function new();
			occl_gap     = OCCL_GAP_RST;
			col_limit    = COL_LIMIT_RST;
			graze_ratio  = GRAZE_RATIO_RST;
			errors       = 0;
			points_in    = 0;
			frames       = 0;
			results_seen = 0;
			picked_seen  = 0;
			curv_seen    = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			for (int k = 0; k < WIN_DEPTH; k++) begin
				range_win[k] = '0;
				col_win[k]   = '0;
				pick_win[k]  = 1'b0;
				curv_win[k]  = '0;
				cok_win[k]   = 1'b0;
			end
			next_pos = '0;
			held     = 0;
		endfunction

		// Register writes keep only the bits of the field.
		function void set_register(logic [1:0] idx, logic [APB_DW-1:0] value);
			case (idx)
				REG_OCCL_GAP:    occl_gap    = value[RANGE_W-1:0];
				REG_COL_LIMIT:   col_limit   = value[COL_W-1:0];
				REG_GRAZE_RATIO: graze_ratio = value[RATIO_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [APB_DW-1:0] register_value(logic [1:0] idx);
			case (idx)
				REG_OCCL_GAP:    return APB_DW'(occl_gap);
				REG_COL_LIMIT:   return APB_DW'(col_limit);
				REG_GRAZE_RATIO: return APB_DW'(graze_ratio);
				default:         return '0;
			endcase
		endfunction

		function longint unsigned span(longint unsigned a, longint unsigned b);
			return (a > b) ? a - b : b - a;
		endfunction

		// Queue the result for the point k places behind the newest one.
		function void owe(int k, logic last);
			result_t e;
			e.point_position  = next_pos - POS_W'(k);
			e.curvature       = cok_win[k] ? curv_win[k] : '0;
			e.curvature_valid = cok_win[k];
			e.picked          = pick_win[k];
			e.result_last     = last;
			owed_marks = {owed_marks, e};
		endfunction

		// One accepted point transfer: slide the windows, evaluate, release.
		function void take_point(point_t p);
			longint             d;
			longint unsigned    mag;
			longint unsigned    lim;
			logic [RANGE_W-1:0] r0;
			logic [RANGE_W-1:0] rn;
			logic [RANGE_W-1:0] rp;
			int                 top;

			points_in++;
			for (int k = OLDEST; k > 0; k--) begin
				range_win[k] = range_win[k-1];
				col_win[k]   = col_win[k-1];
				pick_win[k]  = pick_win[k-1];
				curv_win[k]  = curv_win[k-1];
				cok_win[k]   = cok_win[k-1];
			end
			range_win[0] = p.range_mm;
			col_win[0]   = p.column;
			pick_win[0]  = 1'b0;
			curv_win[0]  = '0;
			cok_win[0]   = 1'b0;

			// The center gets its curvature with five newer and five older points.
			if (held >= NEIGHBORS) begin
				d = -NEIGHBORS * longint'(range_win[CENTER]);
				for (int k = 0; k <= NEIGHBORS; k++)
					if (k != CENTER)
						d += longint'(range_win[k]);
				mag = (d < 0) ? longint'(-d) : longint'(d);
				curv_win[CENTER] = CURV_W'(mag * mag);
				cok_win[CENTER]  = 1'b1;
			end

			// Occlusion and grazing tests on the point one behind the center.
			if (held >= NEIGHBORS + 1) begin
				r0  = range_win[CHECKED];
				rn  = range_win[CENTER];
				rp  = range_win[CHECKED+1];
				lim = longint'(graze_ratio) * longint'(r0);
				if (span(col_win[CENTER], col_win[CHECKED]) < longint'(col_limit)) begin
					if (r0 > rn && longint'(r0 - rn) > longint'(occl_gap)) begin
						for (int k = CHECKED; k <= OLDEST; k++)
							pick_win[k] = 1'b1;
					end else if (rn > r0 && longint'(rn - r0) > longint'(occl_gap)) begin
						for (int k = 0; k <= CENTER; k++)
							pick_win[k] = 1'b1;
					end
				end
				if (span(rp, r0) * GRAZE_SCALE > lim && span(rn, r0) * GRAZE_SCALE > lim)
					pick_win[CHECKED] = 1'b1;
				owe(OLDEST, 1'b0);
			end

			// The end mark flushes every held point, newest last.
			if (p.frame_last) begin
				top = (held >= NEIGHBORS) ? NEIGHBORS : held;
				for (int k = top; k >= 0; k--)
					owe(k, k == 0);
				clear_frame();
				frames++;
			end else begin
				if (held < WIN_DEPTH)
					held++;
				next_pos++;
			end
		endfunction

		function void flag(string what, longint unsigned want, longint unsigned got);
			errors++;
			if (errors <= PRINT_CAP)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		endfunction

		// One accepted result transfer against the oldest owed result.
		function void match_result(result_t got);
			result_t want;

			results_seen++;
			if (got.picked === 1'b1)
				picked_seen++;
			if (got.curvature_valid === 1'b1)
				curv_seen++;
			if (owed_marks.size() == 0) begin
				errors++;
				if (errors <= PRINT_CAP)
					$display("%0t: result at position %0d arrived, expected none, got one",
						$time, got.point_position);
				return;
			end
			want = owed_marks.pop_front();
			if (got.point_position !== want.point_position)
				flag("point_position", want.point_position, got.point_position);
			if (got.curvature !== want.curvature)
				flag("curvature", want.curvature, got.curvature);
			if (got.curvature_valid !== want.curvature_valid)
				flag("curvature_valid", want.curvature_valid, got.curvature_valid);
			if (got.picked !== want.picked)
				flag("picked", want.picked, got.picked);
			if (got.result_last !== want.result_last)
				flag("result_last", want.result_last, got.result_last);
		endfunction
	endclass

endpackage

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LiDAR curvature and occlusion marker: testbench
// Drives point frames with random gaps and result stalls, writes the three
// thresholds over APB at several settings, reads them back, and checks every
// result transfer field by field against the expected-result tracker.
// ----------------------------------------------------------------------------
module tb;
	import lcom_pkg::*;
	import mark_track_pkg::*;

	localparam int RANGE_TOP     = (1 << RANGE_W) - 1;
	localparam int COL_TOP       = (1 << COL_W) - 1;
	localparam int RATIO_TOP     = (1 << RATIO_W) - 1;
	localparam int SETTLE_CYCLES = 20;
	localparam int IDLE_LIMIT    = 4000;
	localparam int PHASE_POINTS  = 14;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              point_valid;
	logic              point_stall;
	point_t            point;
	logic              result_valid;
	logic              result_stall;
	result_t           result;

	point_mark_tracker tracker;
	int                idle_cycles = 0;

	lidar_curvature_occlusion_marker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.point        (point),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// 20 ns clock.
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Idle length for either side: mostly none, some short, a few long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Every accepted transfer is noted first, then results are checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (point_valid && !point_stall)
				tracker.take_point(point);
			if (result_valid && !result_stall)
				tracker.match_result(result);
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((point_valid && !point_stall) || (result_valid && !result_stall) ||
				(psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: no transfer for %0d cycles", idle_cycles);
			$display("tb: done, errors");
			$finish;
		end
	end

	// Result side: free runs broken by stalls of random length.
	initial begin
		int free_run;
		int hold;
		result_stall = 1'b0;
		forever begin
			free_run = $urandom_range(1, 12);
			repeat (free_run) @(posedge clk);
			hold = pick_gap();
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Each APB transfer drops psel and penable before the next setup phase.
	task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		tracker.set_register(idx, data);
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [1:0] idx, output logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Read all three thresholds back and compare with the written values.
	task automatic check_registers();
		logic [1:0]        regs [3];
		logic [APB_DW-1:0] value;
		regs = '{REG_OCCL_GAP, REG_COL_LIMIT, REG_GRAZE_RATIO};
		foreach (regs[i]) begin
			apb_read(regs[i], value);
			if (value !== tracker.register_value(regs[i]))
				tracker.flag("register read", tracker.register_value(regs[i]), value);
		end
	endtask

	// Junk in the upper bits checks that each register keeps only its field.
	task automatic write_settings(input int gap, input int limit, input int ratio);
		logic [APB_DW-1:0] wdata;
		wdata = $urandom();
		wdata[RANGE_W-1:0] = RANGE_W'(gap);
		apb_write(REG_OCCL_GAP, wdata);
		wdata = $urandom();
		wdata[COL_W-1:0] = COL_W'(limit);
		apb_write(REG_COL_LIMIT, wdata);
		wdata = $urandom();
		wdata[RATIO_W-1:0] = RATIO_W'(ratio);
		apb_write(REG_GRAZE_RATIO, wdata);
		check_registers();
	endtask

	// One point transfer, after an optional gap with valid low.
	task automatic send_point(input int rng, input int col, input logic last);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point.range_mm   <= RANGE_W'(rng);
		point.column     <= COL_W'(col);
		point.frame_last <= last;
		point_valid      <= 1'b1;
		do @(posedge clk); while (point_stall);
	endtask

	// Stop sending, wait for every owed result, then let the block go quiet.
	task automatic settle(input int extra);
		point_valid <= 1'b0;
		@(posedge clk);
		while (tracker.owed_marks.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// A frame of npts points: steady surfaces with noise, jumps and outliers.
	task automatic send_frame(input int npts, input int pause_at);
		int         base;
		int         rng;
		int         roll;
		logic [COL_W-1:0] col;
		base = $urandom_range(200, 250000);
		col  = COL_W'($urandom_range(0, COL_TOP));
		for (int i = 0; i < npts; i++) begin
			if (i == pause_at)
				settle(0);
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				rng = $urandom_range(0, RANGE_TOP);
			end else begin
				if (roll < 20)
					base = $urandom_range(0, RANGE_TOP);
				rng = base + int'($urandom_range(0, 40)) - 20;
				if (rng < 0)
					rng = 0;
				if (rng > RANGE_TOP)
					rng = RANGE_TOP;
			end
			if ($urandom_range(0, 11) == 0)
				col = COL_W'($urandom_range(0, COL_TOP));
			else
				col = col + 1'b1;
			send_point(rng, col, i == npts - 1);
		end
	endtask

	initial begin
		int sent;
		int len;
		int roll;
		int target;
		bit first;

		tracker     = new();
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		point_valid = 1'b0;
		point       = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_registers();

		// Single-point frame at the field maxima.
		send_point(RANGE_TOP, COL_TOP, 1'b1);

		// Near-side occlusion at position 7, far-side occlusion and grazing at 8.
		for (int i = 0; i < 16; i++)
			send_point((i == 8) ? 5000 : ((i > 8) ? 800 : 1000 + (i % 3) * 5),
				100 + i, i == 15);

		// Eleven points: the only valid curvature, at position 5, is the largest.
		for (int i = 0; i < 11; i++)
			send_point((i == CENTER) ? 0 : RANGE_TOP, i, i == 10);
		settle(SETTLE_CYCLES);

		// Random frames under four threshold settings.
		sent = 0;
		for (int phase = 1; phase <= 4; phase++) begin
			case (phase)
				1: write_settings(0, COL_TOP, 0);
				2: write_settings(RANGE_TOP, 0, GRAZE_SCALE);
				3: write_settings($urandom_range(0, 2000), $urandom_range(1, 40), RATIO_TOP);
				default: begin
					write_settings($urandom_range(100, 5000), $urandom_range(2, 20),
						$urandom_range(1, 200));
					apb_write(REG_UNUSED, $urandom());
					check_registers();
				end
			endcase
			target = sent + PHASE_POINTS;
			first  = 1'b1;
			while (sent < target) begin
				roll = $urandom_range(0, 9);
				if (roll < 6)
					len = $urandom_range(12, 24);
				else if (roll < 8)
					len = $urandom_range(1, 11);
				else
					len = $urandom_range(25, 40);
				// Once, hold the sender mid-frame until all owed results are out.
				send_frame(len, (phase == 2 && first) ? len / 2 : -1);
				sent  += len;
				first  = 1'b0;
			end
			settle(SETTLE_CYCLES);
		end

		$display("tb: %0d points in %0d frames, %0d results checked (%0d picked, %0d curvatures)",
			tracker.points_in, tracker.frames, tracker.results_seen,
			tracker.picked_seen, tracker.curv_seen);
		$display("tb: reset values, directed edge frames and four threshold settings, %0d mismatches",
			tracker.errors);
		if (tracker.errors == 0 && tracker.owed_marks.size() == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
